// ===== design/fmdq_pkg.sv =====
// ----------------------------------------------------------------------------
// fmdq_pkg
// Shared types, constants and calendar helpers for the full moon date query.
// ----------------------------------------------------------------------------
package fmdq_pkg;

  localparam int OP_W     = 2;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;

  localparam int DN_W     = 22;  // day number from 1 Jan 1999, year 9999 at most
  localparam int DB_W     = 24;  // days before a trial year
  localparam int YV_W     = 15;  // trial years up to 1999 + 16383
  localparam int ACC_INT_W = 23; // integer bits of the lunation accumulator
  localparam int KB       = 17;  // bits of the lunation index
  localparam int YB       = 14;  // bits of the year offset search
  localparam int CNT_W    = 5;
  localparam int LQ_W     = 9;   // year / 100
  localparam int LC_W     = 13;  // leap day count
  localparam int REM_W    = 9;   // day within year

  localparam int EPOCH_YEAR       = 1999;
  localparam int FIRST_VALID_YEAR = 2000;
  localparam int L_EPOCH          = 484;  // leap days counted up to 1998

  localparam int DEC_SCALE = 100000000;
  localparam int F_INT     = 2;
  localparam int F_FRAC    = 49878487;
  localparam int P_INT     = 29;
  localparam int P_FRAC    = 53059027;

  // x / 100 as (x * 5243) >> 19, exact for x below 2^15
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP100_SH = 19;
  // q / 40 as (q * 205) >> 13, exact for q below 2^9
  localparam logic [7:0]  RECIP40     = 8'd205;
  localparam int          RECIP40_SH  = 13;

  typedef enum logic [1:0] {
    OP_IS_FULL = 2'd0,
    OP_PREV    = 2'd1,
    OP_NEXT    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    YU_IN,
    YU_TRIAL,
    YU_FOUND
  } yu_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DY1,
    S_DY2,
    S_CHK,
    S_KS,
    S_PICK,
    S_YS1,
    S_YS2,
    S_YS3,
    S_YL1,
    S_YL2,
    S_MD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             ld_in;
    yu_src_t          yu_src;
    logic             chk;
    logic             ks_init;
    logic             ks_step;
    logic             pick;
    logic             ys_keep;
    logic             md;
    logic             out_ld;
    logic [CNT_W-1:0] bit_idx;
  } cmd_t;

  typedef struct packed {
    logic bad;
    op_t  op;
  } sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic lp);
    logic [DAY_W-1:0] len;
    if (m == 4'd2) len = lp ? 5'd29 : 5'd28;
    else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) len = 5'd30;
    else len = 5'd31;
    return len;
  endfunction

  function automatic logic [REM_W-1:0] cum_before(input logic [MONTH_W-1:0] m,
                                                  input logic lp);
    logic [REM_W-1:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (lp && m > 4'd2) c = c + 9'd1;
    return c;
  endfunction

  // Decimal fraction num / 1e8 as fb binary fraction bits, rounded half up.
  function automatic logic [63:0] frac_to_fixed(input int num, input int fb);
    logic [63:0] r;
    logic [63:0] q;
    int          i;
    r = 64'(num);
    q = '0;
    for (i = 0; i < fb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= 64'(DEC_SCALE)) begin
        r = r - 64'(DEC_SCALE);
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= 64'(DEC_SCALE)) q = q + 64'd1;
    return q;
  endfunction

endpackage

// ===== design/fmdq_yr.sv =====
// ----------------------------------------------------------------------------
// fmdq_yr
// Two-stage year unit: days before 1 Jan of a year, and its leap flag.
// ----------------------------------------------------------------------------
module fmdq_yr (
  input  logic                       clk,
  input  logic [fmdq_pkg::YV_W-1:0]  v,
  output logic [fmdq_pkg::DB_W-1:0]  db,
  output logic                       lp
);
  import fmdq_pkg::*;

  logic [YV_W-1:0]  v_r;
  logic [LQ_W-1:0]  qa_r, qb_r;
  logic [YV_W-1:0]  vm1, vm1_r;
  logic [27:0]      pa, pb;
  logic [16:0]      ra, rb;
  logic [LC_W-1:0]  la, lb;
  logic [YV_W-1:0]  yo;
  logic [DB_W-1:0]  db_nxt, db_r;
  logic             lp_nxt, lp_r;

  // stage 1: quotients by 100 of the year and the year before
  assign vm1 = v - 15'd1;
  assign pa  = {13'd0, v} * {15'd0, RECIP100};
  assign pb  = {13'd0, vm1} * {15'd0, RECIP100};

  always_ff @(posedge clk) begin
    v_r   <= v;
    vm1_r <= vm1;
    qa_r  <= pa[RECIP100_SH +: LQ_W];
    qb_r  <= pb[RECIP100_SH +: LQ_W];
  end

  // stage 2: leap day counts x/4 - x/100 + x/400 - x/4000
  always_comb begin
    ra     = {8'd0, qa_r} * {9'd0, RECIP40};
    rb     = {8'd0, qb_r} * {9'd0, RECIP40};
    la     = v_r[YV_W-1:2] - LC_W'(qa_r) + LC_W'(qa_r[LQ_W-1:2])
             - LC_W'(ra[16:RECIP40_SH]);
    lb     = vm1_r[YV_W-1:2] - LC_W'(qb_r) + LC_W'(qb_r[LQ_W-1:2])
             - LC_W'(rb[16:RECIP40_SH]);
    yo     = v_r - YV_W'(EPOCH_YEAR);
    db_nxt = DB_W'(yo) * DB_W'(365) + DB_W'(lb) - DB_W'(L_EPOCH);
    lp_nxt = (la != lb);
  end

  always_ff @(posedge clk) begin
    db_r <= db_nxt;
    lp_r <= lp_nxt;
  end

  assign db = db_r;
  assign lp = lp_r;

endmodule

// ===== design/fmdq_dp.sv =====
// ----------------------------------------------------------------------------
// fmdq_dp
// Datapath: date check, day number, lunation search, date recovery.
// ----------------------------------------------------------------------------
module fmdq_dp #(
  parameter int MAX_YEAR  = 4095,
  parameter int FRAC_BITS = 32
) (
  input  logic                          clk,
  input  fmdq_pkg::cmd_t                cmd,
  input  logic [fmdq_pkg::OP_W-1:0]     in_opcode,
  input  logic [fmdq_pkg::YEAR_W-1:0]   in_year,
  input  logic [fmdq_pkg::MONTH_W-1:0]  in_month,
  input  logic [fmdq_pkg::DAY_W-1:0]    in_day,
  output fmdq_pkg::sts_t                sts,
  output logic                          out_status,
  output logic                          out_is_full,
  output logic [fmdq_pkg::YEAR_W-1:0]   out_moon_year,
  output logic [fmdq_pkg::MONTH_W-1:0]  out_moon_month,
  output logic [fmdq_pkg::DAY_W-1:0]    out_moon_day
);
  import fmdq_pkg::*;

  localparam int AW = FRAC_BITS + ACC_INT_W;
  localparam logic [AW-1:0] FQ =
    AW'((64'(F_INT) << FRAC_BITS) + frac_to_fixed(F_FRAC, FRAC_BITS));
  localparam logic [AW-1:0] PQ =
    AW'((64'(P_INT) << FRAC_BITS) + frac_to_fixed(P_FRAC, FRAC_BITS));

  logic [OP_W-1:0]    op_r;
  logic [YEAR_W-1:0]  y_r;
  logic [MONTH_W-1:0] m_r;
  logic [DAY_W-1:0]   d_r;
  logic [DN_W-1:0]    dn_r, n_r;
  logic               inv_r, full_r;
  logic [AW-1:0]      acc_r, step_r;
  logic [YB-1:0]      o_r;
  logic [YEAR_W-1:0]  ry_r;
  logic [MONTH_W-1:0] rm_r;
  logic [DAY_W-1:0]   rd_r;

  logic               st_r, fl_r;
  logic [YEAR_W-1:0]  oy_r;
  logic [MONTH_W-1:0] om_r;
  logic [DAY_W-1:0]   od_r;

  logic [YV_W-1:0]    yu_v;
  logic [DB_W-1:0]    db;
  logic               lp;
  logic [YB-1:0]      ybit;
  logic               bad;
  logic [DN_W-1:0]    dn;
  logic [AW-1:0]      trial, nxt_t, prv2_t;
  logic [ACC_INT_W-1:0] prev_d;
  logic               hit;
  logic [REM_W-1:0]   rem;
  logic [MONTH_W-1:0] mm;
  logic [DAY_W-1:0]   dd;

  assign ybit = YB'(1) << cmd.bit_idx[3:0];

  always_comb begin
    unique case (cmd.yu_src)
      YU_IN:    yu_v = {1'b0, y_r};
      YU_TRIAL: yu_v = YV_W'(EPOCH_YEAR) + {1'b0, o_r | ybit};
      YU_FOUND: yu_v = YV_W'(EPOCH_YEAR) + {1'b0, o_r};
      default:  yu_v = {1'b0, y_r};
    endcase
  end

  fmdq_yr u_yr (
    .clk (clk),
    .v   (yu_v),
    .db  (db),
    .lp  (lp)
  );

  // date check and day number, year unit holds the queried year
  always_comb begin
    bad = (y_r < YEAR_W'(FIRST_VALID_YEAR)) || (y_r > YEAR_W'(MAX_YEAR)) ||
          (m_r == 4'd0) || (m_r > 4'd12) || (d_r == 5'd0) ||
          (d_r > month_len(m_r, lp));
    dn  = DN_W'(db) + DN_W'(cum_before(m_r, lp)) + DN_W'(d_r);
  end

  // lunation search and pick
  always_comb begin
    trial  = acc_r + step_r;
    nxt_t  = acc_r + PQ;
    prv2_t = acc_r - PQ;
    prev_d = acc_r[AW-1:FRAC_BITS];
    hit    = (prev_d == ACC_INT_W'(dn_r));
  end

  // month and day from the day within the found year
  always_comb begin
    rem = REM_W'(DB_W'(n_r) - db);
    mm  = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (rem > cum_before(MONTH_W'(i), lp)) mm = MONTH_W'(i);
    end
    dd  = DAY_W'(rem - cum_before(mm, lp));
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r <= in_opcode;
      y_r  <= in_year;
      m_r  <= in_month;
      d_r  <= in_day;
    end
    if (cmd.chk) begin
      dn_r   <= dn;
      inv_r  <= bad;
      full_r <= 1'b0;
      ry_r   <= '0;
      rm_r   <= '0;
      rd_r   <= '0;
    end
    if (cmd.ks_init) begin
      acc_r  <= FQ;
      step_r <= PQ << (KB - 1);
    end
    if (cmd.ks_step) begin
      if (trial[AW-1:FRAC_BITS] <= ACC_INT_W'(dn_r)) acc_r <= trial;
      step_r <= step_r >> 1;
    end
    if (cmd.pick) begin
      full_r <= hit;
      o_r    <= '0;
      if (op_t'(op_r) == OP_PREV)
        n_r <= hit ? DN_W'(prv2_t[AW-1:FRAC_BITS]) : DN_W'(prev_d);
      else
        n_r <= DN_W'(nxt_t[AW-1:FRAC_BITS]);
    end
    if (cmd.ys_keep) begin
      if (db < DB_W'(n_r)) o_r <= o_r | ybit;
    end
    if (cmd.md) begin
      ry_r <= YEAR_W'(YV_W'(EPOCH_YEAR) + {1'b0, o_r});
      rm_r <= mm;
      rd_r <= dd;
    end
    if (cmd.out_ld) begin
      st_r <= inv_r;
      fl_r <= !inv_r && (op_t'(op_r) == OP_IS_FULL) && full_r;
      oy_r <= ry_r;
      om_r <= rm_r;
      od_r <= rd_r;
    end
  end

  assign sts.bad = bad;
  assign sts.op  = op_t'(op_r);

  assign out_status     = st_r;
  assign out_is_full    = fl_r;
  assign out_moon_year  = oy_r;
  assign out_moon_month = om_r;
  assign out_moon_day   = od_r;

endmodule

// ===== design/fmdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmdq_ctrl
// Sequencer: steps the datapath through check, search and recovery.
// ----------------------------------------------------------------------------
module fmdq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fmdq_pkg::sts_t  sts,
  output fmdq_pkg::cmd_t  cmd
);
  import fmdq_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DY1;
      S_DY1:  state_nxt = S_DY2;
      S_DY2:  state_nxt = S_CHK;
      S_CHK: begin
        if (sts.bad || sts.op == OP_NONE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_KS;
          cnt_nxt   = CNT_W'(KB - 1);
        end
      end
      S_KS: begin
        if (cnt_r == '0) state_nxt = S_PICK;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_PICK: begin
        if (sts.op == OP_IS_FULL) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_YS1;
          cnt_nxt   = CNT_W'(YB - 1);
        end
      end
      S_YS1:  state_nxt = S_YS2;
      S_YS2:  state_nxt = S_YS3;
      S_YS3: begin
        if (cnt_r == '0) begin
          state_nxt = S_YL1;
        end else begin
          state_nxt = S_YS1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      S_YL1:  state_nxt = S_YL2;
      S_YL2:  state_nxt = S_MD;
      S_MD:   state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.yu_src  = YU_IN;
    cmd.bit_idx = cnt_r;
    unique case (state_r)
      S_IDLE:  cmd.ld_in   = in_valid;
      S_CHK: begin
        cmd.chk     = 1'b1;
        cmd.ks_init = 1'b1;
      end
      S_KS:    cmd.ks_step = 1'b1;
      S_PICK:  cmd.pick    = 1'b1;
      S_YS1:   cmd.yu_src  = YU_TRIAL;
      S_YS3:   cmd.ys_keep = 1'b1;
      S_YL1:   cmd.yu_src  = YU_FOUND;
      S_MD:    cmd.md      = 1'b1;
      S_DONE:  cmd.out_ld  = slot_free;
      default: cmd.yu_src  = YU_IN;
    endcase
  end

  always_comb begin
    if (cmd.out_ld) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_ks_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KS && cnt_r == '0) |=> state_r == S_PICK)
    else $error("lunation search did not end after its last bit");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DY1)
    else $error("accepted transaction did not start the date check");

  a_out_ld: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_valid_r)
    else $error("result load did not raise out_valid");

endmodule

// ===== design/full_moon_date_query_unit.sv =====
// ----------------------------------------------------------------------------
// full_moon_date_query_unit
// One transaction at a time; the next is taken in the cycle after the
//   result is loaded. An invalid date or opcode 3 skips both searches,
//   opcode 0 skips the year search. Run time is set by the 17-step
//   lunation search and the 14-bit year search through the two-stage
//   year unit.
// Reset: synchronous, active low; clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module full_moon_date_query_unit #(
  parameter int MAX_YEAR  = 4095,
  parameter int FRAC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fmdq_pkg::OP_W-1:0]     in_opcode,
  input  logic [fmdq_pkg::YEAR_W-1:0]   in_year,
  input  logic [fmdq_pkg::MONTH_W-1:0]  in_month,
  input  logic [fmdq_pkg::DAY_W-1:0]    in_day,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic                          out_is_full,
  output logic [fmdq_pkg::YEAR_W-1:0]   out_moon_year,
  output logic [fmdq_pkg::MONTH_W-1:0]  out_moon_month,
  output logic [fmdq_pkg::DAY_W-1:0]    out_moon_day
);
  import fmdq_pkg::*;

  // The date is checked and turned into a day number via the year unit
  // (closed form leap count, constant reciprocals). Full moon k sits at
  // floor(F + k*P) in fixed point; the last moon not after the day is found
  // by a bit-serial search on k, one add and compare a cycle. The chosen
  // day goes back to a date by a bit-serial search on the year offset, and
  // the month comes from a cumulative-days table.
  cmd_t cmd;
  sts_t sts;

  fmdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmdq_dp #(
    .MAX_YEAR  (MAX_YEAR),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_opcode      (in_opcode),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .sts            (sts),
    .out_status     (out_status),
    .out_is_full    (out_is_full),
    .out_moon_year  (out_moon_year),
    .out_moon_month (out_moon_month),
    .out_moon_day   (out_moon_day)
  );

endmodule

// ===== tb/sv/full_moon_date_query_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// full_moon_date_query_unit_tb
// Drives dated moon queries through the unit under random idling on both
// handshakes and checks each result against a predicted calendar answer.
// ----------------------------------------------------------------------------
module full_moon_date_query_unit_tb;
  import fmdq_pkg::*;

  localparam int MAX_YR      = 4095;
  localparam int FB          = 32;
  localparam int STALL_LIMIT = 20000;  // cycles with no transaction at all
  localparam int N_RANDOM    = 1600;

  typedef struct {
    logic              status;
    logic              is_full;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } moon_ans_t;

  // Expected-answer store plus the calendar and lunation arithmetic
  class moon_scoreboard;
    moon_ans_t pending[$];
    int        errors;
    logic [63:0] f_fix, p_fix;

    // decimal fraction n / 1e8 as FB binary bits, rounded half up
    function logic [63:0] dec_frac(int unsigned n);
      logic [63:0] rem, acc;
      rem = 64'(n);
      acc = '0;
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        acc = acc << 1;
        if (rem >= 64'd100000000) begin
          rem = rem - 64'd100000000;
          acc = acc | 64'd1;
        end
      end
      if (2 * rem >= 64'd100000000) acc = acc + 64'd1;
      return acc;
    endfunction

    function new();
      errors = 0;
      f_fix = (64'd2 << FB) + dec_frac(49878487);
      p_fix = (64'd29 << FB) + dec_frac(53059027);
    endfunction

    // 4000-year exception comes first
    function bit is_leap(int unsigned y);
      if (y % 4000 == 0) return 0;
      if (y % 400 == 0) return 1;
      if (y % 100 == 0) return 0;
      return y % 4 == 0;
    endfunction

    function int unsigned mlen(int unsigned m, bit lp);
      if (m == 2) return lp ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function int unsigned ylen(int unsigned y);
      return is_leap(y) ? 366 : 365;
    endfunction

    function moon_ans_t answer(op_t op, int unsigned y, int unsigned m, int unsigned d);
      moon_ans_t   a;
      int unsigned dn, pick, yy, mm;
      logic [63:0] t;
      longint unsigned k0;
      a = '{1'b0, 1'b0, '0, '0, '0};
      if (y < 2000 || y > MAX_YR || m < 1 || m > 12 || d < 1 || d > mlen(m, is_leap(y))) begin
        a.status = 1'b1;
        return a;
      end
      dn = d;
      for (int unsigned i = 1999; i < y; i++) dn += ylen(i);
      for (int unsigned i = 1; i < m; i++) dn += mlen(i, is_leap(y));
      // start at lunation dn / 31, short of the day, to keep the walk brief
      k0 = dn / 31;
      t = f_fix + k0 * p_fix;
      while ((t >> FB) <= dn) t += p_fix;
      if (op == OP_IS_FULL) begin
        a.is_full = ((t - p_fix) >> FB) == dn;
        return a;
      end
      if (op == OP_NONE) return a;
      if (op == OP_PREV)
        pick = (((t - p_fix) >> FB) == dn) ? 32'((t - 2 * p_fix) >> FB)
                                           : 32'((t - p_fix) >> FB);
      else
        pick = 32'(t >> FB);
      yy = 1999;
      while (pick > ylen(yy)) begin
        pick -= ylen(yy);
        yy++;
      end
      mm = 1;
      while (mm < 12 && pick > mlen(mm, is_leap(yy))) begin
        pick -= mlen(mm, is_leap(yy));
        mm++;
      end
      a.year = YEAR_W'(yy);
      a.month = MONTH_W'(mm);
      a.day = DAY_W'(pick);
      return a;
    endfunction

    function void note_query(op_t op, int unsigned y, int unsigned m, int unsigned d);
      pending.push_back(answer(op, y, m, d));
    endfunction

    function void check_answer(moon_ans_t got);
      moon_ans_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.is_full !== want.is_full) begin
        $display("%0t: is_full exp %0d got %0d", $time, want.is_full, got.is_full);
        errors++;
      end
      if (got.year !== want.year) begin
        $display("%0t: moon_year exp %0d got %0d", $time, want.year, got.year);
        errors++;
      end
      if (got.month !== want.month) begin
        $display("%0t: moon_month exp %0d got %0d", $time, want.month, got.month);
        errors++;
      end
      if (got.day !== want.day) begin
        $display("%0t: moon_day exp %0d got %0d", $time, want.day, got.day);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_opcode = '0;
  logic [YEAR_W-1:0]  in_year = '0;
  logic [MONTH_W-1:0] in_month = '0;
  logic [DAY_W-1:0]   in_day = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status, out_is_full;
  logic [YEAR_W-1:0]  out_moon_year;
  logic [MONTH_W-1:0] out_moon_month;
  logic [DAY_W-1:0]   out_moon_day;

  moon_scoreboard sb = new();
  int  idle_cycles = 0;

  full_moon_date_query_unit #(.MAX_YEAR(MAX_YR), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_year(in_year), .in_month(in_month), .in_day(in_day),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_is_full(out_is_full),
    .out_moon_year(out_moon_year), .out_moon_month(out_moon_month),
    .out_moon_day(out_moon_day)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or a short one, now and then a long wait
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Present one query and hold it until the handshake completes. Called at a
  // rising edge; the prediction is noted on the accepting edge.
  task automatic send_query(op_t op, int unsigned y, int unsigned m, int unsigned d);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_year   <= YEAR_W'(y);
    in_month  <= MONTH_W'(m);
    in_day    <= DAY_W'(d);
    do @(posedge clk); while (!in_ready);
    sb.note_query(op, y, m, d);
  endtask

  // Idle the sender between transactions; valid drops only if a gap follows
  task automatic sender_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int unsigned y, m, d, r;
    op_t op;
    r = $urandom_range(0, 99);
    op = op_t'((r < 4) ? 3 : $urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (r < 8) y = $urandom_range(0, 16383);           // mostly out of range
    else if (r < 16) y = $urandom_range(0, 1) ? $urandom_range(2000, 2010)
                                             : $urandom_range(MAX_YR - 10, MAX_YR);
    else if (r < 20) y = 4000;                          // the odd common year
    else y = $urandom_range(2000, MAX_YR);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      m = $urandom_range(1, 12);
      // end of month is where the calendar edges live
      if ($urandom_range(0, 3) == 0) d = sb.mlen(m, sb.is_leap(y)) + $urandom_range(0, 1);
      else d = $urandom_range(1, sb.mlen(m, sb.is_leap(y)));
    end
    send_query(op, y, m, d);
  endtask

  // Sink side: random back-pressure, each accepted result checked in order
  always @(posedge clk) begin
    int g;
    if (rst_n && out_valid && out_ready)
      sb.check_answer('{out_status, out_is_full, out_moon_year, out_moon_month, out_moon_day});
    if (!rst_n) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) != 0) out_ready <= 1'b1;
    else begin
      g = gap_len();
      out_ready <= (g == 0);
    end
  end

  // Watchdog: a stretch of STALL_LIMIT without a transaction on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range ends, leap rules, bad fields, every opcode
    send_query(OP_IS_FULL, 2000, 1, 1);    sender_gap();
    send_query(OP_PREV, 2000, 1, 1);       sender_gap();
    send_query(OP_NEXT, 2000, 1, 1);       sender_gap();
    send_query(OP_NEXT, MAX_YR, 12, 31);   sender_gap();   // may land past the top year
    send_query(OP_PREV, MAX_YR, 12, 31);   sender_gap();
    send_query(OP_IS_FULL, 1999, 12, 31);  sender_gap();
    send_query(OP_NEXT, MAX_YR + 1, 1, 1); sender_gap();
    send_query(OP_PREV, 16383, 15, 31);    sender_gap();
    send_query(OP_IS_FULL, 0, 0, 0);       sender_gap();
    send_query(OP_NEXT, 2024, 13, 1);      sender_gap();
    send_query(OP_NEXT, 2024, 4, 31);      sender_gap();
    send_query(OP_PREV, 2024, 6, 0);       sender_gap();
    send_query(OP_NEXT, 2000, 2, 29);      sender_gap();   // 400 rule
    send_query(OP_NEXT, 2100, 2, 29);      sender_gap();   // century common
    send_query(OP_NEXT, 4000, 2, 29);      sender_gap();   // 4000 exception
    send_query(OP_PREV, 4000, 3, 1);       sender_gap();
    send_query(OP_NEXT, 2024, 2, 29);      sender_gap();
    send_query(OP_NONE, 2024, 5, 5);       sender_gap();
    send_query(OP_NONE, 2024, 5, 32 - 1);  sender_gap();
    send_query(OP_NONE, 1234, 5, 5);       sender_gap();
    // 2000-01-21 and the day before it: full moon day queried all three ways
    send_query(OP_IS_FULL, 2000, 1, 21);   sender_gap();
    send_query(OP_PREV, 2000, 1, 21);      sender_gap();
    send_query(OP_NEXT, 2000, 1, 21);      sender_gap();
    send_query(OP_IS_FULL, 2000, 1, 20);   sender_gap();

    for (int i = 0; i < N_RANDOM; i++) begin
      send_random();
      sender_gap();
      // hold off once until the unit has fully drained
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
